FILE: src/lpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared constants for the Lorentz and polarization correction.
// ----------------------------------------------------------------------------
package lpf_pkg;

    localparam int COMPONENT_WIDTH_DEF = 21;
    localparam int FRACTION_BITS_DEF   = 16;
    localparam int CFG_WIDTH           = 63;
    localparam int CFG_INDEX_WIDTH     = 2;
    localparam int LF_WIDTH            = 17;
    localparam int PF_WIDTH            = 18;
    localparam int RATIO_WIDTH         = 32;
    localparam int FRAC_REG_WIDTH      = 17;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BEAM     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NORMAL   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRACTION = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS     = 2'd3;

    localparam logic [1:0] ST_VALID     = 2'd0;
    localparam logic [1:0] ST_SATURATED = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;

endpackage

FILE: src/lorentz_polarization_factor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorentz_polarization_factor
// Lorentz factor, polarization factor and their ratio per scattered vector.
// ----------------------------------------------------------------------------
//  channel   signals                                   handshake
//  config    cfg_write, cfg_index, cfg_data            write enable
//  input     start, scatter_x/y/z                      start & !busy
//  result    done, lorentz_factor .. status            one-cycle strobe
//
//  One vector per cycle; done rises once the word has passed three product
//  and sum stages, the 22-stage square root, one stage, the 67-stage
//  parallel divider layer, three stages, the 33-stage ratio divider and
//  the output register.
//  busy stays low: the receiver cannot stall and the pipeline never holds.
//  Reset clears the configuration and the valid bits of every stage.
// ----------------------------------------------------------------------------
module lorentz_polarization_factor #(
    parameter int COMPONENT_WIDTH = lpf_pkg::COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = lpf_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lpf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [lpf_pkg::CFG_WIDTH-1:0]     cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [20:0]                scatter_x,
    input  logic signed [20:0]                scatter_y,
    input  logic signed [20:0]                scatter_z,
    output logic                              done,
    output logic [lpf_pkg::LF_WIDTH-1:0]      lorentz_factor,
    output logic [lpf_pkg::PF_WIDTH-1:0]      polarization_factor,
    output logic [lpf_pkg::RATIO_WIDTH-1:0]   correction_ratio,
    output logic [1:0]                        status
);
    import lpf_pkg::*;

    localparam int CW  = COMPONENT_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int PW  = 2 * CW;
    localparam int SQW = PW + 2;
    localparam int RTW = SQW / 2;
    localparam int TW  = 3 * CW + 4;
    localparam int DPW = PW + 2;
    localparam int NRW = 2 * RTW;
    localparam int P3N = DPW + F;
    localparam int PBW = 4 * F + 4;

    logic [CFG_WIDTH-1:0]      beam_reg;
    logic [CFG_WIDTH-1:0]      normal_reg;
    logic [FRAC_REG_WIDTH-1:0] frac_reg;
    logic [CFG_WIDTH-1:0]      axis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_reg   <= '0;
            normal_reg <= '0;
            frac_reg   <= '0;
            axis_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BEAM:     beam_reg   <= cfg_data;
                REG_NORMAL:   normal_reg <= cfg_data;
                REG_FRACTION: frac_reg   <= cfg_data[FRAC_REG_WIDTH-1:0];
                REG_AXIS:     axis_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic signed [CW-1:0] s0 [3];
    logic signed [CW-1:0] pn [3];
    logic signed [CW-1:0] m2 [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s0[k] = signed'(beam_reg[k*CW +: CW]);
            pn[k] = signed'(normal_reg[k*CW +: CW]);
            m2[k] = signed'(axis_reg[k*CW +: CW]);
        end
    end

    // stage 1: products
    logic                  v1_reg;
    logic signed [CW-1:0]  s1_reg [3];
    logic signed [PW-1:0]  sq1_reg [3];
    logic signed [PW-1:0]  sq0_reg [3];
    logic signed [PW-1:0]  pd_reg [3];
    logic signed [PW-1:0]  bd_reg [3];
    logic signed [PW:0]    cr_reg [3];
    logic signed [CW-1:0]  si [3];

    always_comb
    begin
        si[0] = CW'(scatter_x);
        si[1] = CW'(scatter_y);
        si[2] = CW'(scatter_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_reg[k]  <= si[k];
            sq1_reg[k] <= si[k] * si[k];
            sq0_reg[k] <= s0[k] * s0[k];
            pd_reg[k]  <= pn[k] * si[k];
            bd_reg[k]  <= s0[k] * si[k];
        end
        cr_reg[0] <= (PW+1)'(m2[1] * s0[2]) - (PW+1)'(m2[2] * s0[1]);
        cr_reg[1] <= (PW+1)'(m2[2] * s0[0]) - (PW+1)'(m2[0] * s0[2]);
        cr_reg[2] <= (PW+1)'(m2[0] * s0[1]) - (PW+1)'(m2[1] * s0[0]);
    end

    // stage 2: sums and triple-product terms
    logic                   v2_reg;
    logic [SQW-1:0]         n0_reg, n1_reg;
    logic signed [DPW-1:0]  pdot_reg, bdot_reg;
    logic signed [TW-1:0]   tp_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n0_reg   <= SQW'(sq0_reg[0]) + SQW'(sq0_reg[1]) + SQW'(sq0_reg[2]);
        n1_reg   <= SQW'(sq1_reg[0]) + SQW'(sq1_reg[1]) + SQW'(sq1_reg[2]);
        pdot_reg <= DPW'(pd_reg[0]) + DPW'(pd_reg[1]) + DPW'(pd_reg[2]);
        bdot_reg <= DPW'(bd_reg[0]) + DPW'(bd_reg[1]) + DPW'(bd_reg[2]);
        for (int k = 0; k < 3; k++)
        begin
            tp_reg[k] <= TW'(s1_reg[k] * cr_reg[k]);
        end
    end

    // stage 3: triple product magnitude
    logic                   v3_reg;
    logic [SQW-1:0]         n0b_reg, n1b_reg;
    logic signed [DPW-1:0]  pdot3_reg, bdot3_reg;
    logic [TW-1:0]          ta_reg;
    logic signed [TW-1:0]   tsum;

    assign tsum = tp_reg[0] + tp_reg[1] + tp_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n0b_reg   <= n0_reg;
        n1b_reg   <= n1_reg;
        pdot3_reg <= pdot_reg;
        bdot3_reg <= bdot_reg;
        ta_reg    <= tsum[TW-1] ? TW'(-tsum) : TW'(tsum);
    end

    // square roots, run in parallel
    localparam int SA = SQW + 2 * DPW + TW;
    logic [SA-1:0]  sqa_side, sqa_oside, sqb_oside;
    logic           sqa_v, sqb_v;
    logic [RTW-1:0] r0_w, r1_w;
    logic           zero3;

    assign zero3    = (n0b_reg == '0) || (n1b_reg == '0);
    assign sqa_side = {n1b_reg, pdot3_reg, bdot3_reg, ta_reg};

    lpf_isqrt #(.NW(SQW), .SW(SA)) u_sqrt0 (
        .clk(clk), .rst_n(rst_n), .in_valid(v3_reg), .in_val(n0b_reg),
        .in_side(sqa_side), .out_valid(sqa_v), .out_root(r0_w),
        .out_side(sqa_oside)
    );

    lpf_isqrt #(.NW(SQW), .SW(1)) u_sqrt1 (
        .clk(clk), .rst_n(rst_n), .in_valid(v3_reg), .in_val(n1b_reg),
        .in_side(zero3), .out_valid(sqb_v), .out_root(r1_w),
        .out_side(sqb_oside[0])
    );
    assign sqb_oside[SA-1:1] = '0;

    // stage 4: root product, magnitudes for division
    logic                  v4_reg, z4_reg;
    logic [NRW-1:0]        rr_reg;
    logic [RTW-1:0]        r1_4_reg;
    logic [TW-1:0]         ta4_reg;
    logic [DPW-1:0]        pmag4_reg;
    logic                  pneg4_reg;
    logic [P3N-1:0]        bmag4_reg;
    logic                  bneg4_reg;
    logic signed [DPW-1:0] pd_w, bd_w;

    assign pd_w = sqa_oside[TW+DPW +: DPW];
    assign bd_w = sqa_oside[TW +: DPW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= sqa_v & sqb_v;
        end
    end

    always_ff @(posedge clk)
    begin
        z4_reg    <= sqb_oside[0];
        rr_reg    <= NRW'(r0_w) * NRW'(r1_w);
        r1_4_reg  <= r1_w;
        ta4_reg   <= sqa_oside[TW-1:0];
        pneg4_reg <= pd_w[DPW-1];
        pmag4_reg <= pd_w[DPW-1] ? DPW'(-pd_w) : DPW'(pd_w);
        bneg4_reg <= bd_w[DPW-1];
        bmag4_reg <= {(bd_w[DPW-1] ? DPW'(-bd_w) : DPW'(bd_w)), {F{1'b0}}};
    end

    // first division layer: L, P1, P3 in parallel
    localparam int DN = P3N > TW ? P3N : TW;
    localparam int DD = NRW;
    localparam int S5 = 3;
    logic           lq_v, p1_v, p3_v;
    logic [DN-1:0]  lq_w, p1_w, p3_w;
    logic [S5-1:0]  s5_w, s5a_w, s5b_w;

    lpf_divider #(.NW(DN), .DW(DD), .SW(S5)) u_div_l (
        .clk(clk), .rst_n(rst_n), .in_valid(v4_reg), .in_num(DN'(ta4_reg)),
        .in_den(rr_reg), .in_side({z4_reg, pneg4_reg, bneg4_reg}),
        .out_valid(lq_v), .out_quot(lq_w), .out_side(s5_w)
    );
    lpf_divider #(.NW(DN), .DW(DD), .SW(S5)) u_div_p1 (
        .clk(clk), .rst_n(rst_n), .in_valid(v4_reg), .in_num(DN'(pmag4_reg)),
        .in_den(DD'(r1_4_reg)), .in_side('0),
        .out_valid(p1_v), .out_quot(p1_w), .out_side(s5a_w)
    );
    lpf_divider #(.NW(DN), .DW(DD), .SW(S5)) u_div_p3 (
        .clk(clk), .rst_n(rst_n), .in_valid(v4_reg), .in_num(DN'(bmag4_reg)),
        .in_den(rr_reg), .in_side('0),
        .out_valid(p3_v), .out_quot(p3_w), .out_side(s5b_w)
    );

    // stage 5: clamp and square
    localparam int QW  = 2 * F + 4;
    localparam int P1W = CW + 1;
    localparam int Q1W = 2 * P1W;
    logic                 v5_reg, z5_reg;
    logic [LF_WIDTH-1:0]  lq5_reg;
    logic [Q1W-1:0]       p1sq_reg;
    logic [QW-1:0]        p3sq_reg;
    logic [F:0]           f5_reg;
    logic [DN-1:0]        p3c;
    logic [DN-1:0]        lim;

    // |P1| stays below 2^(CW+1); the stray P3 is clamped to at most 2^(F+2).
    assign lim = DN'(1) << (F + 2);
    assign p3c = (p3_w > lim) ? lim : p3_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= lq_v & p1_v & p3_v;
        end
    end

    always_ff @(posedge clk)
    begin
        z5_reg   <= s5_w[2] | s5a_w[0] | s5b_w[0];
        lq5_reg  <= (lq_w > DN'(1 << F)) ? LF_WIDTH'(1 << F) : LF_WIDTH'(lq_w);
        p1sq_reg <= Q1W'(p1_w[P1W-1:0]) * Q1W'(p1_w[P1W-1:0]);
        p3sq_reg <= QW'(p3c[F+2:0]) * QW'(p3c[F+2:0]);
        f5_reg   <= (frac_reg > FRAC_REG_WIDTH'(1 << F)) ? (F+1)'(1 << F)
                                                         : (F+1)'(frac_reg);
    end

    // stage 6: weight terms
    localparam int TAW = (Q1W > 2 * F ? Q1W : 2 * F) + 2;
    logic                   v6_reg, z6_reg;
    logic [LF_WIDTH-1:0]    lq6_reg;
    logic signed [PBW-1:0]  pa_reg, pb_reg;
    logic signed [TAW-1:0]  ta_w;
    logic signed [QW+1:0]   tb_w;
    logic signed [F+2:0]    wa_w;

    assign ta_w = (TAW'(1) << (2 * F)) - TAW'(p1sq_reg);
    assign tb_w = ((QW+2)'(1) << (2 * F)) + (QW+2)'(p3sq_reg);
    assign wa_w = (F+3)'(1 << F) - (F+3)'(2 * f5_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        z6_reg  <= z5_reg;
        lq6_reg <= lq5_reg;
        pa_reg  <= PBW'(wa_w) * PBW'(ta_w);
        pb_reg  <= PBW'($signed({1'b0, f5_reg})) * PBW'(tb_w);
    end

    // stage 7: P
    logic                 v7_reg, z7_reg, pbad7_reg;
    logic [LF_WIDTH-1:0]  lq7_reg;
    logic [PF_WIDTH-1:0]  pq7_reg;
    logic signed [PBW-1:0] psum;
    logic [PBW-1:0]       psh;

    assign psum = pa_reg + pb_reg;
    assign psh  = PBW'(psum) >> (2 * F);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else
        begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        z7_reg    <= z6_reg;
        lq7_reg   <= lq6_reg;
        pbad7_reg <= (psum <= 0) || (psh == '0);
        pq7_reg   <= (psh > PBW'(2 << F)) ? PF_WIDTH'(2 << F) : PF_WIDTH'(psh);
    end

    // ratio division
    localparam int RN = LF_WIDTH + F;
    localparam int RS = 2 + LF_WIDTH + PF_WIDTH;
    logic             rq_v;
    logic [RN-1:0]    rq_w;
    logic [RS-1:0]    rs_w;
    logic [PF_WIDTH-1:0] rden;

    assign rden = pbad7_reg ? PF_WIDTH'(1) : pq7_reg;

    lpf_divider #(.NW(RN), .DW(PF_WIDTH), .SW(RS)) u_div_r (
        .clk(clk), .rst_n(rst_n), .in_valid(v7_reg),
        .in_num({lq7_reg, {F{1'b0}}}), .in_den(rden),
        .in_side({z7_reg, pbad7_reg, lq7_reg, pq7_reg}),
        .out_valid(rq_v), .out_quot(rq_w), .out_side(rs_w)
    );

    // output register
    logic                    done_reg;
    logic [LF_WIDTH-1:0]     lf_reg;
    logic [PF_WIDTH-1:0]     pf_reg;
    logic [RATIO_WIDTH-1:0]  cr_out_reg;
    logic [1:0]              st_reg;
    logic                    oz, ob, osat;
    logic [LF_WIDTH-1:0]     olq;
    logic [PF_WIDTH-1:0]     opq;

    assign oz   = rs_w[RS-1];
    assign ob   = rs_w[RS-2];
    assign olq  = rs_w[PF_WIDTH +: LF_WIDTH];
    assign opq  = rs_w[PF_WIDTH-1:0];
    assign osat = (RN > RATIO_WIDTH) && ((rq_w >> RATIO_WIDTH) != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rq_v;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (oz)
        begin
            lf_reg     <= '0;
            pf_reg     <= '0;
            cr_out_reg <= '0;
            st_reg     <= ST_INVALID;
        end
        else if (ob)
        begin
            lf_reg     <= olq;
            pf_reg     <= '0;
            cr_out_reg <= '0;
            st_reg     <= ST_INVALID;
        end
        else if (osat)
        begin
            lf_reg     <= olq;
            pf_reg     <= opq;
            cr_out_reg <= '1;
            st_reg     <= ST_SATURATED;
        end
        else
        begin
            lf_reg     <= olq;
            pf_reg     <= opq;
            cr_out_reg <= RATIO_WIDTH'(rq_w);
            st_reg     <= ST_VALID;
        end
    end

    assign done                = done_reg;
    assign lorentz_factor      = lf_reg;
    assign polarization_factor = pf_reg;
    assign correction_ratio    = cr_out_reg;
    assign status              = st_reg;
endmodule

FILE: src/lpf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpf_divider
// Pipelined restoring divider, one quotient bit per stage, side data carried.
// ----------------------------------------------------------------------------
module lpf_divider #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quot,
    output logic [SW-1:0] out_side
);
    logic          v_reg   [NW+1];
    logic [NW-1:0] q_reg   [NW+1];
    logic [DW:0]   r_reg   [NW+1];
    logic [DW-1:0] d_reg   [NW+1];
    logic [SW-1:0] s_reg   [NW+1];

    always_comb
    begin
        v_reg[0] = in_valid;
        q_reg[0] = in_num;
        r_reg[0] = '0;
        d_reg[0] = in_den;
        s_reg[0] = in_side;
    end

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic          v_q;
        logic [NW-1:0] q_q;
        logic [DW:0]   r_q;
        logic [DW-1:0] d_q;
        logic [SW-1:0] s_q;
        logic [DW+1:0] sh;
        logic [DW+1:0] df;

        always_comb
        begin
            sh = {r_reg[i], q_reg[i][NW-1]};
            df = sh - {2'b00, d_reg[i]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_q <= 1'b0;
            end
            else
            begin
                v_q <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            d_q <= d_reg[i];
            s_q <= s_reg[i];
            if (!df[DW+1])
            begin
                r_q <= df[DW:0];
                q_q <= {q_reg[i][NW-2:0], 1'b1};
            end
            else
            begin
                r_q <= sh[DW:0];
                q_q <= {q_reg[i][NW-2:0], 1'b0};
            end
        end

        always_comb
        begin
            v_reg[i+1] = v_q;
            q_reg[i+1] = q_q;
            r_reg[i+1] = r_q;
            d_reg[i+1] = d_q;
            s_reg[i+1] = s_q;
        end
    end

    assign out_valid = v_reg[NW];
    assign out_quot  = q_reg[NW];
    assign out_side  = s_reg[NW];
endmodule

FILE: src/lpf_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpf_isqrt
// Pipelined floor square root, one result bit per stage, side data carried.
// ----------------------------------------------------------------------------
module lpf_isqrt #(
    parameter int NW = 46,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [NW-1:0]   in_val,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    output logic [NW/2-1:0] out_root,
    output logic [SW-1:0]   out_side
);
    localparam int RW = (NW + 1) / 2;
    localparam int PW = 2 * RW;

    logic          v_reg [RW+1];
    logic [PW-1:0] n_reg [RW+1];
    logic [RW-1:0] q_reg [RW+1];
    logic [RW+1:0] r_reg [RW+1];
    logic [SW-1:0] s_reg [RW+1];

    always_comb
    begin
        v_reg[0] = in_valid;
        n_reg[0] = PW'(in_val);
        q_reg[0] = '0;
        r_reg[0] = '0;
        s_reg[0] = in_side;
    end

    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic          v_q;
        logic [PW-1:0] n_q;
        logic [RW-1:0] q_q;
        logic [RW+1:0] r_q;
        logic [SW-1:0] s_q;
        logic [RW+1:0] rs;
        logic [RW+1:0] tr;
        logic [RW+2:0] df;

        always_comb
        begin
            rs = {r_reg[i][RW-1:0], n_reg[i][PW-1:PW-2]};
            tr = {q_reg[i], 2'b01};
            df = {1'b0, rs} - {1'b0, tr};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_q <= 1'b0;
            end
            else
            begin
                v_q <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            n_q <= {n_reg[i][PW-3:0], 2'b00};
            s_q <= s_reg[i];
            if (!df[RW+2])
            begin
                r_q <= df[RW+1:0];
                q_q <= {q_reg[i][RW-2:0], 1'b1};
            end
            else
            begin
                r_q <= rs;
                q_q <= {q_reg[i][RW-2:0], 1'b0};
            end
        end

        always_comb
        begin
            v_reg[i+1] = v_q;
            n_reg[i+1] = n_q;
            q_reg[i+1] = q_q;
            r_reg[i+1] = r_q;
            s_reg[i+1] = s_q;
        end
    end

    assign out_valid = v_reg[RW];
    assign out_root  = q_reg[RW][NW/2-1:0];
    assign out_side  = s_reg[RW];
endmodule

FILE: src/lpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpf_checker
// Port-level checks on busy and on the results of the correction block.
// ----------------------------------------------------------------------------
module lpf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        done,
    input logic [16:0] lorentz_factor,
    input logic [17:0] polarization_factor,
    input logic [31:0] correction_ratio,
    input logic [1:0]  status
);
    import lpf_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_lf_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> lorentz_factor <= 17'd65536)
        else $error("lorentz factor above one");
    a_pf_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> polarization_factor <= 18'd131072)
        else $error("polarization factor above two");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_SATURATED |-> correction_ratio == 32'hFFFFFFFF)
        else $error("saturated ratio not at maximum");
    a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_INVALID |-> polarization_factor == '0
            && correction_ratio == '0)
        else $error("invalid result carries values");
endmodule

bind lorentz_polarization_factor lpf_checker u_lpf_checker (
    .clk(clk), .rst_n(rst_n), .busy(busy), .done(done),
    .lorentz_factor(lorentz_factor), .polarization_factor(polarization_factor),
    .correction_ratio(correction_ratio), .status(status)
);
